// File: hdl/pfsa_pkg.sv
// ----------------------------------------------------------------------------
// Free page stack allocator package
// Shared field widths, codes and payload types of the allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int unsigned PAGE_W = 52;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned PAGES_W = 11;
  localparam int unsigned DEF_STACK_DEPTH = 1024;
  localparam int unsigned DEF_MAX_BURST = 64;
  localparam int unsigned WORK_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH = 4;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [1:0] CMD_INIT = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;

  localparam logic REG_BASE_PAGE = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_BADCOUNT = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_ALLOC,
    KIND_FREE,
    KIND_BADCOUNT
  } kind_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [COUNT_W-1:0] count;
    logic [PAGE_W-1:0]  page_number;
  } item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  allocated_page;
    status_e            status;
    logic               last;
    logic [PAGES_W-1:0] pages_free;
  } result_t;

  typedef struct packed {
    kind_e              kind;
    logic [COUNT_W-1:0] count;
    logic [PAGE_W-1:0]  page;
  } work_t;

endpackage

// File: hdl/pfsa_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out queue with fill count.
// ----------------------------------------------------------------------------
module pfsa_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hdl/pfsa_front.sv
// ----------------------------------------------------------------------------
// Allocator command front end
// Accepts commands, checks burst counts and drops unused command codes.
// ----------------------------------------------------------------------------
module pfsa_front #(
  parameter int unsigned MAX_BURST = pfsa_pkg::DEF_MAX_BURST
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfsa_pkg::item_t item_i,
  output logic            full_o,
  output logic            work_push_o,
  output pfsa_pkg::work_t work_o,
  input  logic            work_full_i
);

  import pfsa_pkg::*;

  logic  valid_q, valid_d;
  work_t work_q, work_d;
  logic  accept;
  logic  keep;

  assign full_o      = valid_q & work_full_i;
  assign accept      = push_i & ~full_o;
  assign work_push_o = valid_q;
  assign work_o      = work_q;

  always_comb begin
    keep        = 1'b1;
    work_d      = work_q;
    work_d.count = item_i.count;
    work_d.page  = item_i.page_number;
    work_d.kind  = KIND_INIT;
    unique case (item_i.command)
      CMD_INIT: work_d.kind = KIND_INIT;
      CMD_ALLOC: begin
        if (item_i.count == '0 || item_i.count > COUNT_W'(MAX_BURST)) begin
          work_d.kind = KIND_BADCOUNT;
        end else begin
          work_d.kind = KIND_ALLOC;
        end
      end
      CMD_FREE: work_d.kind = KIND_FREE;
      default: keep = 1'b0;
    endcase
    if (accept) begin
      valid_d = keep;
    end else if (valid_q && !work_full_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

endmodule

// File: hdl/pfsa_back.sv
// ----------------------------------------------------------------------------
// Allocator stack engine
// Holds the page stack memory and carries out init, allocate and free.
// ----------------------------------------------------------------------------
module pfsa_back #(
  parameter int unsigned STACK_DEPTH = pfsa_pkg::DEF_STACK_DEPTH,
  parameter int unsigned OUT_DEPTH   = pfsa_pkg::RES_Q_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [pfsa_pkg::PAGE_W-1:0]      base_page_i,
  input  logic                             work_valid_i,
  input  pfsa_pkg::work_t                  work_i,
  output logic                             work_pop_o,
  output logic                             res_push_o,
  output pfsa_pkg::result_t                res_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   res_cnt_i
);

  import pfsa_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned FCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CW  = (FCW > COUNT_W) ? FCW : COUNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  state_e             state_q, state_d;
  logic [FCW-1:0]     free_q, free_d;
  logic [FCW-1:0]     hw_q, hw_d;
  logic [PAGE_W-1:0]  init_base_q, init_base_d;
  logic [COUNT_W-1:0] remain_q, remain_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_hit_q, rd_hit_d;
  logic               rd_last_q, rd_last_d;
  logic [PAGES_W-1:0] rd_free_q, rd_free_d;
  logic [AW-1:0]      rd_addr_q;
  logic [PAGE_W-1:0]  rd_data_q;
  logic [PAGE_W-1:0]  mem_q [STACK_DEPTH];

  logic [FCW-1:0]     top;
  logic [FCW-1:0]     below;
  logic               rd_en, wr_en;
  logic               idle_space, burst_space;

  assign top         = FCW'(STACK_DEPTH) - free_q;
  assign below       = top - 1'b1;
  assign idle_space  = !rd_valid_q && (res_cnt_i < OCW'(OUT_DEPTH));
  assign burst_space = ({1'b0, res_cnt_i} + (OCW + 1)'(rd_valid_q)) < (OCW + 1)'(OUT_DEPTH);

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    hw_d        = hw_q;
    init_base_d = init_base_q;
    remain_d    = remain_q;
    rd_valid_d  = 1'b0;
    rd_hit_d    = rd_hit_q;
    rd_last_d   = rd_last_q;
    rd_free_d   = rd_free_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    work_pop_o  = 1'b0;
    res_push_o  = 1'b0;
    res_o.allocated_page = '0;
    res_o.status         = STATUS_OK;
    res_o.last           = 1'b1;
    res_o.pages_free     = PAGES_W'(free_q);

    if (rd_valid_q) begin
      res_push_o           = 1'b1;
      res_o.allocated_page = rd_hit_q ? rd_data_q : init_base_q + PAGE_W'(rd_addr_q);
      res_o.last           = rd_last_q;
      res_o.pages_free     = rd_free_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (work_valid_i && idle_space) begin
          work_pop_o = 1'b1;
          res_push_o = 1'b1;
          unique case (work_i.kind)
            KIND_INIT: begin
              free_d           = FCW'(STACK_DEPTH);
              hw_d             = '0;
              init_base_d      = base_page_i;
              res_o.pages_free = PAGES_W'(STACK_DEPTH);
            end
            KIND_BADCOUNT: res_o.status = STATUS_BADCOUNT;
            KIND_ALLOC: begin
              if (CW'(work_i.count) > CW'(free_q)) begin
                res_o.status = STATUS_SHORT;
              end else begin
                res_push_o = 1'b0;
                remain_d   = work_i.count;
                state_d    = ST_BURST;
              end
            end
            KIND_FREE: begin
              if (free_q >= FCW'(STACK_DEPTH)) begin
                res_o.status = STATUS_FULL;
              end else begin
                wr_en            = 1'b1;
                free_d           = free_q + 1'b1;
                res_o.pages_free = PAGES_W'(free_q + 1'b1);
              end
            end
            default: res_o.status = STATUS_OK;
          endcase
        end
      end
      ST_BURST: begin
        if (burst_space) begin
          rd_en      = 1'b1;
          rd_valid_d = 1'b1;
          free_d     = free_q - 1'b1;
          remain_d   = remain_q - 1'b1;
          rd_last_d  = (remain_q == COUNT_W'(1));
          rd_free_d  = PAGES_W'(free_q - 1'b1);
          rd_hit_d   = (top < hw_q);
          if (top >= hw_q) begin
            hw_d = top + 1'b1;
          end
          if (remain_q == COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_q      <= '0;
      hw_q        <= FCW'(STACK_DEPTH);
      init_base_q <= '0;
      remain_q    <= '0;
      rd_valid_q  <= 1'b0;
      rd_hit_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_free_q   <= '0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      hw_q        <= hw_d;
      init_base_q <= init_base_d;
      remain_q    <= remain_d;
      rd_valid_q  <= rd_valid_d;
      rd_hit_q    <= rd_hit_d;
      rd_last_q   <= rd_last_d;
      rd_free_q   <= rd_free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[top[AW-1:0]];
      rd_addr_q <= top[AW-1:0];
    end
    if (wr_en) begin
      mem_q[below[AW-1:0]] <= work_i.page;
    end
  end

endmodule

// File: hdl/page_free_stack_allocator.sv
// ----------------------------------------------------------------------------
// Free page stack allocator
// Hands out and takes back page numbers kept on a stack in memory.
// ----------------------------------------------------------------------------
// Commands enter through push/full and results leave through empty/pop; each
// transfer moves one packed item or result. The user must write base_page over
// the register port only while the block is idle; the block does not enforce
// this. base_page is sampled by the init command. Init, free and every error
// produce one result; a free costs one stack memory write.
// An allocate of N pages produces N results, one page per cycle while the
// result queue has room, set by the stack memory's single registered read port.
// One command is carried out at a time; a small command queue lets new commands
// be taken while the engine works.
// Reset leaves the stack empty with no pages free and base_page at zero; the
// stack memory is not cleared. Entries filled by init are produced from the
// captured base until they are overwritten, so no sweep follows init.
// When the receiver stops popping, the result queue fills, the engine
// pauses, and full rises once the command queue is also occupied.
// ----------------------------------------------------------------------------
module page_free_stack_allocator #(
  parameter int unsigned STACK_DEPTH = pfsa_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MAX_BURST   = pfsa_pkg::DEF_MAX_BURST
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  pfsa_pkg::item_t                 item_i,
  output logic                            empty,
  input  logic                            pop,
  output pfsa_pkg::result_t               result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfsa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfsa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfsa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import pfsa_pkg::*;

  localparam int unsigned OCW = $clog2(RES_Q_DEPTH + 1);

  logic [PAGE_W-1:0] base_page_q;
  logic              cfg_write;
  logic              sel_base;

  work_t             front_work, queue_work;
  logic              front_push, work_full, work_empty, work_pop;
  result_t           back_res;
  logic              res_push;
  logic [OCW-1:0]    res_cnt;

  assign pready    = 1'b1;
  assign sel_base  = (paddr[CFG_ADDR_W-1] == REG_BASE_PAGE);
  assign cfg_write = psel & penable & pwrite & pready & sel_base;
  assign prdata    = sel_base ? CFG_DATA_W'(base_page_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_page_q <= '0;
    end else if (cfg_write) begin
      base_page_q <= pwdata[PAGE_W-1:0];
    end
  end

  pfsa_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .work_push_o (front_push),
    .work_o      (front_work),
    .work_full_i (work_full)
  );

  pfsa_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (WORK_Q_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_work),
    .pop_i   (work_pop),
    .data_o  (queue_work),
    .full_o  (work_full),
    .empty_o (work_empty),
    .count_o ()
  );

  pfsa_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .OUT_DEPTH   (RES_Q_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_page_i  (base_page_q),
    .work_valid_i (~work_empty),
    .work_i       (queue_work),
    .work_pop_o   (work_pop),
    .res_push_o   (res_push),
    .res_o        (back_res),
    .res_cnt_i    (res_cnt)
  );

  pfsa_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .pop_i   (pop),
    .data_o  (result_o),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_cnt)
  );

endmodule

// File: test/tb_page_free_stack_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page stack allocator testbench
// Drives init, allocate and free commands through the command queue, keeps
// its own copy of the page stack to predict every result, and checks each
// popped result field by field. The run covers several base page settings,
// random sender bursts, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_page_free_stack_allocator;
  import pfsa_pkg::*;

  localparam int unsigned DEPTH = DEF_STACK_DEPTH;
  localparam int unsigned BURST_MAX = DEF_MAX_BURST;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] BASE_PAGE_ADDR = CFG_ADDR_W'(8 * REG_BASE_PAGE);
  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct {
    item_t              cmd;
    bit                 typed;
    status_e            status;
    logic [PAGES_W-1:0] pages_free;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  item_t item_i = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  logic [PAGE_W-1:0] stack_pages [DEPTH];
  int unsigned stack_top = DEPTH;
  int unsigned pages_avail = 0;
  logic [PAGE_W-1:0] base_setting = '0;

  result_t pending_results [$];
  int unsigned mismatches = 0;
  bit hold_req = 1'b0;
  bit steady = 1'b0;
  int unsigned burst_left = 0;

  page_free_stack_allocator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatches < 100) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic queue_result(input logic [PAGE_W-1:0] page, input status_e st,
                              input logic last);
    result_t r;
    r.allocated_page = page;
    r.status = st;
    r.last = last;
    r.pages_free = pages_avail[PAGES_W-1:0];
    pending_results.push_back(r);
  endtask

  task automatic predict_pages(input item_t cmd);
    int unsigned k;
    case (cmd.command)
      CMD_INIT: begin
        for (k = 0; k < DEPTH; k++) begin
          stack_pages[k] = base_setting + PAGE_W'(k);
        end
        stack_top = 0;
        pages_avail = DEPTH;
        queue_result('0, STATUS_OK, 1'b1);
      end
      CMD_ALLOC: begin
        if (cmd.count == 0 || cmd.count > BURST_MAX) begin
          queue_result('0, STATUS_BADCOUNT, 1'b1);
        end else if (cmd.count > pages_avail || stack_top >= DEPTH) begin
          queue_result('0, STATUS_SHORT, 1'b1);
        end else begin
          for (k = 0; k < cmd.count; k++) begin
            pages_avail--;
            queue_result(stack_pages[stack_top], STATUS_OK, k == cmd.count - 1);
            stack_top++;
          end
        end
      end
      CMD_FREE: begin
        if (pages_avail >= DEPTH || stack_top == 0) begin
          queue_result('0, STATUS_FULL, 1'b1);
        end else begin
          stack_top--;
          stack_pages[stack_top] = cmd.page_number;
          pages_avail++;
          queue_result('0, STATUS_OK, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && pop && !empty) begin
      got = result_o;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result page=%h status=%0d last=%0d free=%0d",
                         got.allocated_page, got.status, got.last, got.pages_free));
      end else begin
        want = pending_results.pop_front();
        if (got.allocated_page !== want.allocated_page || got.status !== want.status ||
            got.last !== want.last || got.pages_free !== want.pages_free) begin
          report($sformatf("page %h/%h status %0d/%0d last %0d/%0d free %0d/%0d",
                           got.allocated_page, want.allocated_page, got.status,
                           want.status, got.last, want.last, got.pages_free,
                           want.pages_free));
        end
      end
    end
  end

  // Receiver: stall patterns change every stretch; a hold request blocks pops.
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned tick;
    mode = 0;
    left = 0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          default: pop <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_item(input item_t cmd);
    push <= 1'b1;
    item_i <= cmd;
    do @(posedge clk_i); while (full);
  endtask

  task automatic pace;
    if (!steady) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained;
    push <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_base_page(input logic [PAGE_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= BASE_PAGE_ADDR;
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[PAGE_W-1:0] !== value) begin
      report($sformatf("base_page read back %h, wrote %h", prdata[PAGE_W-1:0], value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    base_setting = value;
  endtask

  function automatic logic [PAGE_W-1:0] random_page;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PAGE_MAX;
      default: return raw[PAGE_W-1:0];
    endcase
  endfunction

  function automatic item_t random_cmd(input int unsigned alloc_pct);
    item_t cmd;
    int unsigned pick;
    cmd.command = CMD_FREE;
    cmd.count = COUNT_W'($urandom);
    cmd.page_number = random_page();
    if ($urandom_range(0, 99) < alloc_pct) begin
      cmd.command = CMD_ALLOC;
      cmd.count = ($urandom_range(0, 99) < 85) ? COUNT_W'($urandom_range(1, 8))
                                               : COUNT_W'($urandom_range(9, BURST_MAX));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        cmd.command = CMD_INIT;
      end else if (pick < 12) begin
        cmd.command = CMD_ALLOC;
        cmd.count = ($urandom_range(0, 1) == 0) ? '0
                                                : COUNT_W'($urandom_range(BURST_MAX + 1, 127));
      end else if (pick < 16) begin
        cmd.command = CMD_UNUSED;
      end
    end
    return cmd;
  endfunction

  function automatic row_t make_row(input logic [1:0] command, input int unsigned count,
                                    input logic [PAGE_W-1:0] page, input bit typed,
                                    input status_e st, input int unsigned pf);
    row_t row;
    row.cmd.command = command;
    row.cmd.count = COUNT_W'(count);
    row.cmd.page_number = page;
    row.typed = typed;
    row.status = st;
    row.pages_free = PAGES_W'(pf);
    return row;
  endfunction

  initial begin
    row_t rows [$];
    result_t typed_result;
    item_t cmd;
    logic [PAGE_W-1:0] phase_base [4];
    int unsigned phase_alloc [4];
    int unsigned phase;
    int unsigned sent;
    int unsigned n;

    rows.push_back(make_row(CMD_ALLOC, 1, '0, 1'b1, STATUS_SHORT, 0));
    rows.push_back(make_row(CMD_ALLOC, 0, '0, 1'b1, STATUS_BADCOUNT, 0));
    rows.push_back(make_row(CMD_ALLOC, 127, PAGE_MAX, 1'b1, STATUS_BADCOUNT, 0));
    rows.push_back(make_row(CMD_ALLOC, 65, '0, 1'b1, STATUS_BADCOUNT, 0));
    rows.push_back(make_row(CMD_ALLOC, 64, '0, 1'b1, STATUS_SHORT, 0));
    rows.push_back(make_row(CMD_FREE, 0, PAGE_MAX, 1'b1, STATUS_OK, 1));
    rows.push_back(make_row(CMD_FREE, 127, '0, 1'b1, STATUS_OK, 2));
    rows.push_back(make_row(CMD_ALLOC, 3, '0, 1'b1, STATUS_SHORT, 2));
    rows.push_back(make_row(CMD_ALLOC, 2, '0, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_UNUSED, 5, PAGE_MAX, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_INIT, 0, '0, 1'b1, STATUS_OK, DEPTH));
    rows.push_back(make_row(CMD_FREE, 0, PAGE_MAX, 1'b1, STATUS_FULL, DEPTH));
    rows.push_back(make_row(CMD_ALLOC, 64, '0, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_ALLOC, 1, '0, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_FREE, 0, 52'h5_5555_5555_5555, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_FREE, 0, 52'hA_AAAA_AAAA_AAAA, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_ALLOC, 3, '0, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_ALLOC, 127, '0, 1'b0, STATUS_OK, 0));
    rows.push_back(make_row(CMD_ALLOC, 64, '0, 1'b0, STATUS_OK, 0));

    phase_base[0] = PAGE_MAX;
    phase_base[1] = PAGE_W'({$urandom, $urandom});
    phase_base[2] = PAGE_MAX - PAGE_W'(DEPTH / 2);
    phase_base[3] = '0;
    phase_alloc[0] = 50;
    phase_alloc[1] = 85;
    phase_alloc[2] = 30;
    phase_alloc[3] = 55;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].cmd);
      if (rows[i].typed) begin
        n = pending_results.size();
        predict_pages(rows[i].cmd);
        while (pending_results.size() > n) void'(pending_results.pop_back());
        typed_result.allocated_page = '0;
        typed_result.status = rows[i].status;
        typed_result.last = 1'b1;
        typed_result.pages_free = rows[i].pages_free;
        pending_results.push_back(typed_result);
      end else begin
        predict_pages(rows[i].cmd);
      end
      pace();
    end

    for (phase = 0; phase < 4; phase++) begin
      set_base_page(phase_base[phase]);
      cmd = '0;
      cmd.command = CMD_INIT;
      send_item(cmd);
      predict_pages(cmd);
      pace();
      sent = 1;
      while (sent < 105) begin
        if (phase == 1 && sent == 20) begin
          hold_req = 1'b1;
          steady = 1'b1;
        end
        if (phase == 1 && sent == 60) begin
          steady = 1'b0;
        end
        if (phase == 2 && sent == 50) begin
          wait_drained();
        end
        cmd = random_cmd(phase_alloc[phase]);
        send_item(cmd);
        predict_pages(cmd);
        if (cmd.command != CMD_UNUSED) begin
          sent++;
        end
        pace();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
